[rtl/core/vwf_pkg.sv]
package vwf_pkg;

  localparam int HEAD_FRAC_BITS = 16;
  localparam int HEAD_W         = 32;
  // meters in Q32, nonnegative head only
  localparam int H_W            = HEAD_W - 1 + 32 - HEAD_FRAC_BITS;
  localparam int SQ_W           = (H_W + 1) / 2;
  localparam int C_W            = 44;
  localparam int ST_W           = 3;

  localparam logic [15:0] ANGLE_LIMIT = 16'd46080;
  localparam logic [47:0] FLOW_MAX    = '1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_SEL   = 3'd1,
    ST_BAD_GEOM  = 3'd2,
    ST_BELOW_MIN = 3'd3,
    ST_BAD_UNIT  = 3'd4,
    ST_SAT       = 3'd5
  } status_e;

  typedef enum logic [7:0] {
    REG_FLOW_ENABLE    = 8'd0,
    REG_HEAD_SENSOR_ID = 8'd1,
    REG_DISCHARGE_COEF = 8'd2,
    REG_NOTCH_ANGLE    = 8'd3,
    REG_MIN_HEAD       = 8'd4,
    REG_HEAD_UNIT      = 8'd5,
    REG_FLOW_UNIT      = 8'd6,
    REG_FLOW_SENSOR_ID = 8'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_ANGLE,
    CS_ROT,
    CS_CLAMP,
    CS_DIV,
    CS_MUL,
    CS_RND
  } coef_state_e;

  typedef struct packed {
    logic        start;
    logic [15:0] cd;
    logic [15:0] angle;
    logic [1:0]  flow_unit;
  } coef_cfg_t;

  typedef struct packed {
    logic        busy;
    logic        ovf;
    logic [63:0] k;
  } coef_res_t;

  function automatic logic [32:0] unit_scale(input logic [1:0] u);
    logic [32:0] r;
    case (u)
      2'd0:    r = 33'h1_0000_0000;
      2'd1:    r = 33'd42949673;
      2'd2:    r = 33'd4294967;
      2'd3:    r = 33'd109092169;
      default: r = 33'h1_0000_0000;
    endcase
    return r;
  endfunction

  function automatic logic [C_W-1:0] flow_const(input logic [1:0] sel);
    logic [C_W-1:0] r;
    case (sel)
      2'd0:    r = 44'd10144576578;
      2'd1:    r = 44'd10144576578000;
      2'd2:    r = 44'd358252340719;
      default: r = 44'd10144576578;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'd843314856;
      5'd1:    r = 32'd497837829;
      5'd2:    r = 32'd263043836;
      5'd3:    r = 32'd133525158;
      5'd4:    r = 32'd67021686;
      5'd5:    r = 32'd33543515;
      5'd6:    r = 32'd16775850;
      5'd7:    r = 32'd8388437;
      5'd8:    r = 32'd4194282;
      5'd9:    r = 32'd2097149;
      5'd10:   r = 32'd1048575;
      5'd11:   r = 32'd524287;
      5'd12:   r = 32'd262143;
      5'd13:   r = 32'd131071;
      5'd14:   r = 32'd65535;
      5'd15:   r = 32'd32767;
      5'd16:   r = 32'd16383;
      5'd17:   r = 32'd8191;
      5'd18:   r = 32'd4095;
      5'd19:   r = 32'd2047;
      5'd20:   r = 32'd1023;
      5'd21:   r = 32'd511;
      5'd22:   r = 32'd255;
      5'd23:   r = 32'd127;
      5'd24:   r = 32'd63;
      5'd25:   r = 32'd31;
      5'd26:   r = 32'd15;
      5'd27:   r = 32'd7;
      5'd28:   r = 32'd3;
      5'd29:   r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/vwf_if.sv]
interface vwf_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  sensor_id;
  logic [31:0] head;
  modport source (output valid, sensor_id, head, input ready);
  modport sink (input valid, sensor_id, head, output ready);
endinterface

interface vwf_out_if;
  logic        valid;
  logic        ready;
  logic        publish;
  logic [2:0]  status;
  logic [47:0] flow_value;
  logic [1:0]  flow_unit_used;
  logic        unit_fallback;
  logic [7:0]  result_sensor_id;
  modport source (output valid, publish, status, flow_value, flow_unit_used, unit_fallback,
                  result_sensor_id, input ready);
  modport sink (input valid, publish, status, flow_value, flow_unit_used, unit_fallback,
                result_sensor_id, output ready);
endinterface

interface vwf_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/vwf_coef.sv]
module vwf_coef (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vwf_pkg::coef_cfg_t cfg_i,
  output vwf_pkg::coef_res_t res_o
);

  vwf_pkg::coef_state_e state_q, state_d;

  logic signed [33:0] x_q, y_q, z_q;
  logic [5:0]         cnt_q;
  logic               phase_q;
  logic [63:0]        dvd_q, quo_q;
  logic [31:0]        dvs_q, rem_q;
  logic [107:0]       mc_q, acc_q;
  logic [43:0]        ml_q;
  logic [63:0]        k_q;
  logic               ovf_q;
  logic               busy;

  logic [47:0]        ang_prod;
  logic signed [33:0] dx, dy, at;
  logic [32:0]        rem2;
  logic               ge;
  logic [108:0]       sum0, sum1;
  logic [1:0]         sel;

  always_comb begin
    state_d = state_q;
    case (state_q)
      vwf_pkg::CS_IDLE:  state_d = vwf_pkg::CS_IDLE;
      vwf_pkg::CS_ANGLE: state_d = vwf_pkg::CS_ROT;
      vwf_pkg::CS_ROT:   if (cnt_q == 6'd29) state_d = vwf_pkg::CS_CLAMP;
      vwf_pkg::CS_CLAMP: state_d = vwf_pkg::CS_DIV;
      vwf_pkg::CS_DIV:   if (cnt_q == 6'd0) state_d = vwf_pkg::CS_MUL;
      vwf_pkg::CS_MUL:   if (cnt_q == 6'd0) state_d = vwf_pkg::CS_RND;
      vwf_pkg::CS_RND:   state_d = phase_q ? vwf_pkg::CS_IDLE : vwf_pkg::CS_MUL;
      default:           state_d = vwf_pkg::CS_IDLE;
    endcase
    if (cfg_i.start) state_d = vwf_pkg::CS_ANGLE;
  end

  always_comb begin
    busy = (state_q != vwf_pkg::CS_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vwf_pkg::CS_ANGLE;
    end else begin
      state_q <= state_d;
    end
  end

  // half angle in radians Q30
  assign ang_prod = 48'(cfg_i.angle) * 48'(32'd2398762258) + 48'd32768;
  assign dx   = y_q >>> cnt_q[4:0];
  assign dy   = x_q >>> cnt_q[4:0];
  assign at   = $signed({2'b00, vwf_pkg::atan_q30(cnt_q[4:0])});
  assign rem2 = {rem_q, dvd_q[63]};
  assign ge   = rem2 >= {1'b0, dvs_q};
  assign sum0 = {1'b0, acc_q} + (109'd1 << 13);
  assign sum1 = {1'b0, acc_q} + (109'd1 << 31);
  assign sel  = (cfg_i.flow_unit == 2'd3) ? 2'd0 : cfg_i.flow_unit;

  always_ff @(posedge clk_i) begin
    case (state_q)
      vwf_pkg::CS_ANGLE: begin
        x_q   <= 34'sd1 <<< 30;
        y_q   <= '0;
        z_q   <= $signed({2'b00, ang_prod[47:16]});
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end
      vwf_pkg::CS_ROT: begin
        if (!z_q[33]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + at;
        end
        cnt_q <= cnt_q + 6'd1;
      end
      vwf_pkg::CS_CLAMP: begin
        dvd_q <= y_q[33] ? 64'd0 : {y_q[31:0], 32'd0};
        dvs_q <= (x_q[33] || x_q == '0) ? 32'd1 : x_q[31:0];
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= 6'd63;
      end
      vwf_pkg::CS_DIV: begin
        rem_q <= ge ? 32'(rem2 - {1'b0, dvs_q}) : rem2[31:0];
        quo_q <= {quo_q[62:0], ge};
        dvd_q <= {dvd_q[62:0], 1'b0};
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          mc_q    <= 108'({quo_q[62:0], ge});
          ml_q    <= 44'(cfg_i.cd);
          acc_q   <= '0;
          cnt_q   <= 6'd43;
          phase_q <= 1'b0;
        end
      end
      vwf_pkg::CS_MUL: begin
        if (ml_q[0]) acc_q <= acc_q + mc_q;
        mc_q  <= {mc_q[106:0], 1'b0};
        ml_q  <= {1'b0, ml_q[43:1]};
        cnt_q <= cnt_q - 6'd1;
      end
      vwf_pkg::CS_RND: begin
        if (!phase_q) begin
          ovf_q   <= |sum0[108:78];
          mc_q    <= 108'(sum0[77:14]);
          ml_q    <= vwf_pkg::flow_const(sel);
          acc_q   <= '0;
          cnt_q   <= 6'd43;
          phase_q <= 1'b1;
        end else begin
          ovf_q <= ovf_q | (|sum1[108:96]);
          k_q   <= sum1[95:32];
        end
      end
      default: begin
      end
    endcase
  end

  assign res_o.busy = busy;
  assign res_o.ovf  = ovf_q;
  assign res_o.k    = k_q;

endmodule

[rtl/core/vwf_isqrt.sv]
module vwf_isqrt #(
  parameter int W  = 24,
  parameter int TW = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  logic [2*W-1:0] val_i,
  input  logic [TW-1:0]  tag_i,
  output logic           vld_o,
  output logic [W-1:0]   root_o,
  output logic [TW-1:0]  tag_o
);

  logic           vld_q  [W];
  logic [W+1:0]   rem_q  [W];
  logic [W-1:0]   root_q [W];
  logic [2*W-1:0] v_q    [W];
  logic [TW-1:0]  tag_q  [W];

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic           s_vld;
    logic [W+1:0]   s_rem, rem2, trial;
    logic [W-1:0]   s_root;
    logic [2*W-1:0] s_v;
    logic [TW-1:0]  s_tag;
    logic           ge;

    if (i == 0) begin : g_first
      assign s_vld  = vld_i;
      assign s_rem  = '0;
      assign s_root = '0;
      assign s_v    = val_i;
      assign s_tag  = tag_i;
    end else begin : g_next
      assign s_vld  = vld_q[i-1];
      assign s_rem  = rem_q[i-1];
      assign s_root = root_q[i-1];
      assign s_v    = v_q[i-1];
      assign s_tag  = tag_q[i-1];
    end

    assign rem2  = {s_rem[W-1:0], s_v[2*W-1 -: 2]};
    assign trial = {s_root, 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= s_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? rem2 - trial : rem2;
        root_q[i] <= {s_root[W-2:0], ge};
        v_q[i]    <= {s_v[2*W-3:0], 2'b00};
        tag_q[i]  <= s_tag;
      end
    end
  end

  assign vld_o  = vld_q[W-1];
  assign root_o = root_q[W-1];
  assign tag_o  = tag_q[W-1];

endmodule

[rtl/core/vwf_mul.sv]
module vwf_mul #(
  parameter int BW    = 24,
  parameter int SHIFT = 16,
  parameter int TW    = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [63:0]   a_i,
  input  logic [BW-1:0] b_i,
  input  logic          ovf_i,
  input  logic [TW-1:0] tag_i,
  output logic          vld_o,
  output logic [63:0]   p_o,
  output logic          ovf_o,
  output logic [TW-1:0] tag_o
);

  localparam int NB = (BW + 31) / 32;
  localparam int NP = 2 * NB;
  localparam int AW = 64 + BW;
  localparam int BX = 32 * NB;

  logic          vld_q [NP];
  logic          ovf_q [NP];
  logic [63:0]   a_q   [NP];
  logic [BW-1:0] b_q   [NP];
  logic [AW-1:0] acc_q [NP];
  logic [TW-1:0] tag_q [NP];

  // one 32x32 partial product per stage
  for (genvar k = 0; k < NP; k++) begin : g_pp
    localparam int AI = k % 2;
    localparam int BI = k / 2;
    logic          s_vld, s_ovf;
    logic [63:0]   s_a;
    logic [BW-1:0] s_b;
    logic [AW-1:0] s_acc;
    logic [TW-1:0] s_tag;
    logic [BX-1:0] bx;
    logic [63:0]   pp;

    if (k == 0) begin : g_first
      assign s_vld = vld_i;
      assign s_ovf = ovf_i;
      assign s_a   = a_i;
      assign s_b   = b_i;
      assign s_acc = '0;
      assign s_tag = tag_i;
    end else begin : g_next
      assign s_vld = vld_q[k-1];
      assign s_ovf = ovf_q[k-1];
      assign s_a   = a_q[k-1];
      assign s_b   = b_q[k-1];
      assign s_acc = acc_q[k-1];
      assign s_tag = tag_q[k-1];
    end

    assign bx = BX'(s_b);
    assign pp = 64'(s_a[32*AI +: 32]) * 64'(bx[32*BI +: 32]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= s_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ovf_q[k] <= s_ovf;
        a_q[k]   <= s_a;
        b_q[k]   <= s_b;
        acc_q[k] <= s_acc + (AW'(pp) << (32 * (AI + BI)));
        tag_q[k] <= s_tag;
      end
    end
  end

  logic [AW:0]   sum;
  logic          vld_out_q, ovf_out_q;
  logic [63:0]   p_q;
  logic [TW-1:0] tag_out_q;

  assign sum = {1'b0, acc_q[NP-1]} + ((AW+1)'(1) << (SHIFT - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_out_q <= vld_q[NP-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_out_q <= ovf_q[NP-1] | (|sum[AW:64+SHIFT]);
      p_q       <= sum[SHIFT +: 64];
      tag_out_q <= tag_q[NP-1];
    end
  end

  assign vld_o = vld_out_q;
  assign p_o   = p_q;
  assign ovf_o = ovf_out_q;
  assign tag_o = tag_out_q;

endmodule

[rtl/core/vnotch_weir_flow_top.sv]
// channel | dir | beat contents
// in_i    | in  | sensor_id, head (signed Q16.16)
// out_o   | out | publish, status, flow_value (Q32.16), flow_unit_used, unit_fallback,
//         |     | result_sensor_id
// cfg_i   | in  | index, data (register write)
// one reading per cycle while the coefficient unit is idle and the pipeline advances;
// 41 register stages (3 head-scaling stages, 24 square-root stages, 13 multiplier
// stages, output register)
// the Cd * tan(angle/2) * const coefficient comes from a sequential unit (30 cordic
// steps, 64 divide steps, two 44-step multiplies): after reset and after each register
// write the input is held off until it is done
// a stalled output holds its beat; upstream stages advance while the last is empty
module vnotch_weir_flow_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  vwf_in_if.sink      in_i,
  vwf_out_if.source   out_o,
  vwf_cfg_if.sink     cfg_i
);

  localparam int H_W  = vwf_pkg::H_W;
  localparam int SQ_W = vwf_pkg::SQ_W;
  localparam int ST_W = vwf_pkg::ST_W;

  logic        flow_enable_q;
  logic [7:0]  head_sensor_id_q, flow_sensor_id_q;
  logic [15:0] discharge_coeff_q, notch_angle_q;
  logic [31:0] min_head_q;
  logic [2:0]  head_unit_q;
  logic [1:0]  flow_unit_q;
  logic        cfg_fire;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_enable_q     <= 1'b0;
      head_sensor_id_q  <= '0;
      discharge_coeff_q <= '0;
      notch_angle_q     <= '0;
      min_head_q        <= '0;
      head_unit_q       <= '0;
      flow_unit_q       <= '0;
      flow_sensor_id_q  <= '0;
    end else if (cfg_fire) begin
      case (cfg_i.index)
        vwf_pkg::REG_FLOW_ENABLE:    flow_enable_q     <= cfg_i.data[0];
        vwf_pkg::REG_HEAD_SENSOR_ID: head_sensor_id_q  <= cfg_i.data[7:0];
        vwf_pkg::REG_DISCHARGE_COEF: discharge_coeff_q <= cfg_i.data[15:0];
        vwf_pkg::REG_NOTCH_ANGLE:    notch_angle_q     <= cfg_i.data[15:0];
        vwf_pkg::REG_MIN_HEAD:       min_head_q        <= cfg_i.data;
        vwf_pkg::REG_HEAD_UNIT:      head_unit_q       <= cfg_i.data[2:0];
        vwf_pkg::REG_FLOW_UNIT:      flow_unit_q       <= cfg_i.data[1:0];
        vwf_pkg::REG_FLOW_SENSOR_ID: flow_sensor_id_q  <= cfg_i.data[7:0];
        default: begin
        end
      endcase
    end
  end

  vwf_pkg::coef_cfg_t coef_cfg;
  vwf_pkg::coef_res_t coef_res;

  assign coef_cfg.start     = cfg_fire;
  assign coef_cfg.cd        = discharge_coeff_q;
  assign coef_cfg.angle     = notch_angle_q;
  assign coef_cfg.flow_unit = flow_unit_q;

  vwf_coef u_coef (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (coef_cfg),
    .res_o  (coef_res)
  );

  // pipeline advance
  logic out_vld_q, out_load, en, in_fire, m3_vld;

  assign out_load   = !out_vld_q || out_o.ready;
  assign en         = out_load || !m3_vld;
  assign in_i.ready = en && !coef_res.busy;
  assign in_fire    = in_i.valid && in_i.ready;

  vwf_pkg::status_e in_status;

  always_comb begin
    if (!flow_enable_q || in_i.sensor_id != head_sensor_id_q) begin
      in_status = vwf_pkg::ST_NOT_SEL;
    end else if (discharge_coeff_q == '0 || notch_angle_q == '0 ||
                 notch_angle_q >= vwf_pkg::ANGLE_LIMIT) begin
      in_status = vwf_pkg::ST_BAD_GEOM;
    end else if ($signed(in_i.head) < $signed(min_head_q)) begin
      in_status = vwf_pkg::ST_BELOW_MIN;
    end else if (head_unit_q > 3'd3 || in_i.head[31]) begin
      in_status = vwf_pkg::ST_BAD_UNIT;
    end else begin
      in_status = vwf_pkg::ST_OK;
    end
  end

  logic            s0_vld_q, s1_vld_q, s2_vld_q;
  logic [ST_W-1:0] s0_status_q, s1_status_q, s2_status_q;
  logic [30:0]     s0_head_q;
  logic [63:0]     s1_prod_q, h_round;
  logic [H_W-1:0]  s2_h_q;

  assign h_round = s1_prod_q + (64'd1 << (vwf_pkg::HEAD_FRAC_BITS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_fire;
      s1_vld_q <= s0_vld_q;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_status_q <= in_status;
      s0_head_q   <= in_i.head[30:0];
      s1_status_q <= s0_status_q;
      s1_prod_q   <= 64'(s0_head_q) * 64'(vwf_pkg::unit_scale(head_unit_q[1:0]));
      s2_status_q <= s1_status_q;
      s2_h_q      <= h_round[vwf_pkg::HEAD_FRAC_BITS +: H_W];
    end
  end

  logic                sq_vld;
  logic [SQ_W-1:0]     sq_root;
  logic [ST_W+H_W-1:0] sq_tag;

  vwf_isqrt #(.W(SQ_W), .TW(ST_W + H_W)) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s2_vld_q),
    .val_i  ((2*SQ_W)'(s2_h_q)),
    .tag_i  ({s2_status_q, s2_h_q}),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .tag_o  (sq_tag)
  );

  logic                m1_vld, m1_ovf, m2_vld, m2_ovf, m3_ovf;
  logic [63:0]         m1_p, m2_p, m3_p;
  logic [ST_W+H_W-1:0] m1_tag, m2_tag;
  logic [ST_W-1:0]     m3_tag;

  // zero head gives zero flow even when the coefficient overflowed
  vwf_mul #(.BW(SQ_W), .SHIFT(16), .TW(ST_W + H_W)) u_mul_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sq_vld),
    .a_i    (coef_res.k),
    .b_i    (sq_root),
    .ovf_i  (coef_res.ovf && (sq_tag[H_W-1:0] != '0)),
    .tag_i  (sq_tag),
    .vld_o  (m1_vld),
    .p_o    (m1_p),
    .ovf_o  (m1_ovf),
    .tag_o  (m1_tag)
  );

  vwf_mul #(.BW(H_W), .SHIFT(32), .TW(ST_W + H_W)) u_mul_h1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (m1_vld),
    .a_i    (m1_p),
    .b_i    (m1_tag[H_W-1:0]),
    .ovf_i  (m1_ovf),
    .tag_i  (m1_tag),
    .vld_o  (m2_vld),
    .p_o    (m2_p),
    .ovf_o  (m2_ovf),
    .tag_o  (m2_tag)
  );

  vwf_mul #(.BW(H_W), .SHIFT(32), .TW(ST_W)) u_mul_h2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (m2_vld),
    .a_i    (m2_p),
    .b_i    (m2_tag[H_W-1:0]),
    .ovf_i  (m2_ovf),
    .tag_i  (m2_tag[ST_W+H_W-1:H_W]),
    .vld_o  (m3_vld),
    .p_o    (m3_p),
    .ovf_o  (m3_ovf),
    .tag_o  (m3_tag)
  );

  logic [48:0]     flow_r;
  logic            sat, pub;
  logic            publish_d, unit_fallback_d;
  logic [ST_W-1:0] status_d;
  logic [47:0]     flow_d;
  logic [1:0]      used_d;
  logic [7:0]      rid_d;

  logic            publish_q, unit_fallback_q;
  logic [ST_W-1:0] status_q;
  logic [47:0]     flow_q;
  logic [1:0]      used_q;
  logic [7:0]      rid_q;

  assign flow_r = {1'b0, m3_p[63:16]} + 49'(m3_p[15]);
  assign sat    = m3_ovf || flow_r[48];
  assign pub    = (m3_tag == vwf_pkg::ST_OK);

  always_comb begin
    publish_d       = pub;
    status_d        = m3_tag;
    flow_d          = '0;
    used_d          = '0;
    unit_fallback_d = 1'b0;
    rid_d           = '0;
    if (pub) begin
      status_d        = sat ? vwf_pkg::ST_SAT : vwf_pkg::ST_OK;
      flow_d          = sat ? vwf_pkg::FLOW_MAX : flow_r[47:0];
      used_d          = (flow_unit_q == 2'd3) ? 2'd0 : flow_unit_q;
      unit_fallback_d = (flow_unit_q == 2'd3);
      rid_d           = flow_sensor_id_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= m3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      publish_q       <= publish_d;
      status_q        <= status_d;
      flow_q          <= flow_d;
      used_q          <= used_d;
      unit_fallback_q <= unit_fallback_d;
      rid_q           <= rid_d;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.publish          = publish_q;
  assign out_o.status           = status_q;
  assign out_o.flow_value       = flow_q;
  assign out_o.flow_unit_used   = used_q;
  assign out_o.unit_fallback    = unit_fallback_q;
  assign out_o.result_sensor_id = rid_q;

endmodule

[rtl/core/vwf_chk.sv]
module vwf_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic        publish_i,
  input logic [2:0]  status_i,
  input logic [47:0] flow_value_i,
  input logic [1:0]  flow_unit_used_i,
  input logic        unit_fallback_i,
  input logic [7:0]  result_sensor_id_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(flow_value_i) && $stable(status_i))
    else $error("output beat changed while stalled");

  a_withheld_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !publish_i |-> flow_value_i == '0 && result_sensor_id_i == '0 &&
    flow_unit_used_i == '0 && !unit_fallback_i)
    else $error("withheld beat carries nonzero result fields");

  a_pub_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> publish_i == (status_i == vwf_pkg::ST_OK || status_i == vwf_pkg::ST_SAT))
    else $error("publish disagrees with status");

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && status_i == vwf_pkg::ST_SAT |-> flow_value_i == vwf_pkg::FLOW_MAX)
    else $error("saturated beat without full scale flow");

  a_fallback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && unit_fallback_i |-> flow_unit_used_i == 2'd0)
    else $error("unit fallback without m3/s");

endmodule

bind vnotch_weir_flow_top vwf_chk u_vwf_chk (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .valid_i            (out_o.valid),
  .ready_i            (out_o.ready),
  .publish_i          (out_o.publish),
  .status_i           (out_o.status),
  .flow_value_i       (out_o.flow_value),
  .flow_unit_used_i   (out_o.flow_unit_used),
  .unit_fallback_i    (out_o.unit_fallback),
  .result_sensor_id_i (out_o.result_sensor_id)
);
